@@ src/ppc_pkg.sv @@
package ppc_pkg;

  localparam int LEVEL_W    = 16;
  localparam int TORQUE_W   = 16;
  localparam int MT_W       = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int DIV_W      = 32;
  localparam int DVS_W      = 16;
  localparam int DCNT_W     = $clog2(DIV_W);
  localparam int FRAC_W     = 34;
  localparam int FMAG_W     = 33;
  localparam int PROD_W     = FMAG_W + MT_W;
  localparam int MCNT_W     = $clog2(MT_W);

  localparam logic [CFG_IDX_W-1:0] CFG_CAL_LOW     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_HIGH    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TORQUE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RAW_FLOOR   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RAW_CEILING = 3'd5;

  localparam logic signed [FRAC_W-1:0] Q16_ONE         = 34'sd65536;
  localparam logic signed [FRAC_W-1:0] FRAC_LOW_LIMIT  = -34'sd6554;
  localparam logic signed [FRAC_W-1:0] FRAC_HIGH_LIMIT = 34'sd72090;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_AVG,
    S_PREP,
    S_FRAC,
    S_MAG,
    S_MUL,
    S_FIN
  } state_e;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

endpackage

@@ src/ppc_if.sv @@
interface ppc_sample_if #(parameter int ADC_BITS = 10) ();
  logic                valid;
  logic                ready;
  logic [ADC_BITS-1:0] adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink (input valid, input adc_sample, output ready);
endinterface

interface ppc_result_if ();
  logic                                valid;
  logic                                ready;
  logic signed [ppc_pkg::TORQUE_W-1:0] torque_request;
  logic        [ppc_pkg::LEVEL_W-1:0]  cooked_level;
  logic                                out_of_range;

  modport source (output valid, output torque_request, output cooked_level,
                  output out_of_range, input ready);
  modport sink (input valid, input torque_request, input cooked_level,
                input out_of_range, output ready);
endinterface

@@ src/ppc_div.sv @@
module ppc_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ppc_pkg::div_req_t        req_i,
  output logic                     done_o,
  output logic [ppc_pkg::DIV_W-1:0] quot_o
);
  import ppc_pkg::*;

  logic              busy_q;
  logic              done_q;
  logic [DCNT_W-1:0] cnt_q;
  logic [DIV_W-1:0]  dvd_q;
  logic [DVS_W-1:0]  rem_q;
  logic [DVS_W-1:0]  dvs_q;

  logic [DVS_W:0]    shifted;
  logic              fits;
  logic [DVS_W-1:0]  rem_d;
  logic [DIV_W-1:0]  dvd_d;

  // restoring division, one quotient bit per cycle
  always_comb begin
    shifted = {rem_q, dvd_q[DIV_W-1]};
    fits    = shifted >= {1'b0, dvs_q};
    rem_d   = fits ? DVS_W'(shifted - {1'b0, dvs_q}) : DVS_W'(shifted);
    dvd_d   = {dvd_q[DIV_W-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DCNT_W'(DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;

endmodule

@@ src/pedal_position_conditioner_unit.sv @@
// One transaction in flight: a new sample is accepted only after the
// previous result is registered. The datapath runs two 32-step passes
// through the bit-serial divider (window average, pedal fraction) and a
// 15-step shift-add torque multiply; equal calibration points skip the
// fraction pass and the multiply. Reset (async, active low) empties the
// sample window and loads the register defaults; no clearing pass.
module pedal_position_conditioner_unit #(
  parameter int WINDOW   = 8,
  parameter int ADC_BITS = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ppc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ppc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  ppc_sample_if.sink                    in_i,
  ppc_result_if.source                  out_o
);
  import ppc_pkg::*;

  localparam int SUM_W = ADC_BITS + $clog2(WINDOW);
  localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SHIFT = LEVEL_W - ADC_BITS;

  // configuration
  logic [LEVEL_W-1:0] cal_low_q, cal_high_q, raw_floor_q, raw_ceiling_q;
  logic               invert_q;
  logic [MT_W-1:0]    max_torque_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_low_q     <= '0;
      cal_high_q    <= '1;
      invert_q      <= 1'b0;
      max_torque_q  <= '0;
      raw_floor_q   <= '0;
      raw_ceiling_q <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CAL_LOW:     cal_low_q     <= cfg_data_i;
        CFG_CAL_HIGH:    cal_high_q    <= cfg_data_i;
        CFG_INVERT:      invert_q      <= cfg_data_i[0];
        CFG_MAX_TORQUE:  max_torque_q  <= cfg_data_i[MT_W-1:0];
        CFG_RAW_FLOOR:   raw_floor_q   <= cfg_data_i;
        CFG_RAW_CEILING: raw_ceiling_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // control
  state_e state_q, state_d;
  logic   in_ready;
  logic   out_load;
  logic   out_valid_q;
  logic   div_done;
  logic [DIV_W-1:0] quot;
  div_req_t div_req;

  // sample window
  logic [ADC_BITS-1:0] ring_mem [WINDOW];
  logic [WINDOW-1:0]   ring_vld_q;
  logic [IDX_W-1:0]    slot_q;
  logic [ADC_BITS-1:0] old_q;
  logic [ADC_BITS-1:0] sample_q;
  logic [SUM_W-1:0]    sum_q;
  logic [SUM_W-1:0]    sum_new;

  // datapath
  logic [LEVEL_W-1:0]       cooked_q;
  logic                     oor_q;
  logic                     neg_q;
  logic signed [FRAC_W-1:0] frac_q;
  logic                     fsign_q;
  logic [FMAG_W-1:0]        fmag_q;
  logic [PROD_W-1:0]        prod_q;
  logic [MT_W-1:0]          mt_sh_q;
  logic [MCNT_W-1:0]        mcnt_q;

  logic signed [LEVEL_W:0]   num, span;
  logic [LEVEL_W-1:0]        num_abs, span_abs;
  logic                      span_zero;
  logic signed [FRAC_W-1:0]  q_s, fr_sgn, fr_inv;
  logic [FMAG_W:0]           psum;
  logic [DIV_W-1:0]          tmag;
  logic [TORQUE_W-1:0]       torque_fin;

  logic signed [TORQUE_W-1:0] out_torque_q;
  logic [LEVEL_W-1:0]         out_cooked_q;
  logic                       out_oor_q;

  assign in_ready = (state_q == S_IDLE);

  always_comb begin
    sum_new = sum_q - (ring_vld_q[slot_q] ? SUM_W'(old_q) : '0) + SUM_W'(sample_q);

    num       = $signed({1'b0, cooked_q}) - $signed({1'b0, cal_low_q});
    span      = $signed({1'b0, cal_high_q}) - $signed({1'b0, cal_low_q});
    num_abs   = num[LEVEL_W] ? LEVEL_W'(-num) : num[LEVEL_W-1:0];
    span_abs  = span[LEVEL_W] ? LEVEL_W'(-span) : span[LEVEL_W-1:0];
    span_zero = (span == '0);

    q_s    = $signed({2'b00, quot});
    fr_sgn = neg_q ? -q_s : q_s;
    fr_inv = invert_q ? Q16_ONE - fr_sgn : fr_sgn;

    psum = {1'b0, prod_q[PROD_W-1:MT_W]} + (mt_sh_q[0] ? {1'b0, fmag_q} : '0);

    tmag = prod_q[PROD_W-1:LEVEL_W];
    if (!fsign_q) begin
      torque_fin = (tmag > DIV_W'(max_torque_q)) ? TORQUE_W'(max_torque_q)
                                                 : tmag[TORQUE_W-1:0];
    end else begin
      torque_fin = (tmag > DIV_W'(32768)) ? {1'b1, {(TORQUE_W-1){1'b0}}}
                                          : TORQUE_W'(-tmag[TORQUE_W-1:0]);
    end
  end

  always_comb begin
    div_req.start    = (state_q == S_SUM) || (state_q == S_PREP && !span_zero);
    div_req.dividend = (state_q == S_SUM) ? DIV_W'(sum_new) : {num_abs, {LEVEL_W{1'b0}}};
    div_req.divisor  = (state_q == S_SUM) ? DVS_W'(WINDOW) : span_abs;
  end

  ppc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    out_load = 1'b0;
    unique case (state_q)
      S_IDLE: if (in_i.valid) state_d = S_SUM;
      S_SUM:  state_d = S_AVG;
      S_AVG:  if (div_done) state_d = S_PREP;
      S_PREP: state_d = span_zero ? S_FIN : S_FRAC;
      S_FRAC: if (div_done) state_d = S_MAG;
      S_MAG:  state_d = S_MUL;
      S_MUL:  if (mcnt_q == MCNT_W'(MT_W - 1)) state_d = S_FIN;
      S_FIN: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
    endcase
  end

  // window state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_vld_q <= '0;
      slot_q     <= '0;
      sum_q      <= '0;
    end else if (state_q == S_SUM) begin
      ring_vld_q[slot_q] <= 1'b1;
      slot_q <= (slot_q == IDX_W'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
      sum_q  <= sum_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_ready) begin
      old_q    <= ring_mem[slot_q];
      sample_q <= in_i.adc_sample;
    end
    if (state_q == S_SUM) begin
      ring_mem[slot_q] <= sample_q;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_AVG: begin
        if (div_done) cooked_q <= LEVEL_W'(quot[ADC_BITS-1:0]) << SHIFT;
      end
      S_PREP: begin
        oor_q   <= (cooked_q < raw_floor_q) || (cooked_q >= raw_ceiling_q) || span_zero;
        neg_q   <= num[LEVEL_W] ^ span[LEVEL_W];
        prod_q  <= '0;
        fsign_q <= 1'b0;
      end
      S_FRAC: begin
        if (div_done) frac_q <= fr_inv;
      end
      S_MAG: begin
        oor_q   <= oor_q || (frac_q <= FRAC_LOW_LIMIT) || (frac_q >= FRAC_HIGH_LIMIT);
        fsign_q <= frac_q[FRAC_W-1];
        fmag_q  <= frac_q[FRAC_W-1] ? FMAG_W'(-frac_q) : FMAG_W'(frac_q);
        prod_q  <= '0;
        mt_sh_q <= max_torque_q;
        mcnt_q  <= '0;
      end
      S_MUL: begin
        prod_q  <= {psum, prod_q[MT_W-1:1]};
        mt_sh_q <= mt_sh_q >> 1;
        mcnt_q  <= mcnt_q + 1'b1;
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_torque_q <= $signed(torque_fin);
      out_cooked_q <= cooked_q;
      out_oor_q    <= oor_q;
    end
  end

  assign in_i.ready           = in_ready;
  assign out_o.valid          = out_valid_q;
  assign out_o.torque_request = out_torque_q;
  assign out_o.cooked_level   = out_cooked_q;
  assign out_o.out_of_range   = out_oor_q;

endmodule

@@ test/tb_pedal_position_conditioner_unit.sv @@
`timescale 1ns / 100ps

module tb_pedal_position_conditioner_unit;
  import ppc_pkg::*;

  localparam int     ADC_W      = 10;
  localparam longint Q16_UNIT   = 65536;
  localparam longint FRAC_FLOOR = -6554;
  localparam longint FRAC_CEIL  = 72090;
  localparam int     PHASES     = 12;
  localparam int     PHASE_LEN  = 128;

  // indexes past the register list; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_B = 3'd7;

  typedef struct packed {
    logic signed [TORQUE_W-1:0] torque;
    logic [LEVEL_W-1:0]         cooked;
    logic                       oor;
  } reading_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  ppc_sample_if #(.ADC_BITS(ADC_W)) smp_if ();
  ppc_result_if                     res_if ();

  pedal_position_conditioner_unit #(
    .WINDOW  (8),
    .ADC_BITS(ADC_W)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_i      (smp_if),
    .out_o     (res_if)
  );

  // predictor state
  logic [15:0]      cfg_cal_low, cfg_cal_high, cfg_floor, cfg_ceiling;
  logic             cfg_invert;
  logic [14:0]      cfg_max_torque;
  logic [ADC_W-1:0] window_ring [8];
  logic [2:0]       ring_pos;
  logic [12:0]      ring_total;

  logic [ADC_W-1:0] adc_backlog [$];
  reading_t         readings_due [$];

  logic sample_taken;
  logic calm;
  int   src_gap, sink_gap;
  int   samples_sent, readings_seen, faults, flagged, equal_cal_seen, settings_used;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #6_000_000;
    $display("timeout with %0d readings outstanding", readings_due.size());
    $display("CHECK FAILED");
    $finish;
  end

  function automatic void note_fault(input string msg);
    faults++;
    if (faults <= 10) $display("%s", msg);
  endfunction

  function automatic reading_t condition_sample(input logic [ADC_W-1:0] sample);
    reading_t r;
    longint   span;
    longint   frac;
    longint   trq;
    ring_total = ring_total + 13'(sample) - 13'(window_ring[ring_pos]);
    window_ring[ring_pos] = sample;
    ring_pos = ring_pos + 3'd1;
    r.cooked = {ring_total[12:3], 6'd0};
    r.oor = (r.cooked < cfg_floor) || (r.cooked >= cfg_ceiling);
    span = longint'(cfg_cal_high) - longint'(cfg_cal_low);
    if (span == 0) begin
      r.oor = 1'b1;
      trq = 0;
      equal_cal_seen++;
    end else begin
      frac = ((longint'(r.cooked) - longint'(cfg_cal_low)) * Q16_UNIT) / span;
      if (cfg_invert) frac = Q16_UNIT - frac;
      if (frac <= FRAC_FLOOR || frac >= FRAC_CEIL) r.oor = 1'b1;
      trq = (frac * longint'(cfg_max_torque)) / Q16_UNIT;
      if (trq > longint'(cfg_max_torque)) trq = longint'(cfg_max_torque);
      if (trq < -32768) trq = -32768;
    end
    r.torque = trq[15:0];
    if (r.oor) flagged++;
    return r;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    case (idx)
      CFG_CAL_LOW:     cfg_cal_low    = val;
      CFG_CAL_HIGH:    cfg_cal_high   = val;
      CFG_INVERT:      cfg_invert     = val[0];
      CFG_MAX_TORQUE:  cfg_max_torque = val[14:0];
      CFG_RAW_FLOOR:   cfg_floor      = val;
      CFG_RAW_CEILING: cfg_ceiling    = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic set_config(input logic [15:0] lo, input logic [15:0] hi, input logic inv,
                            input logic [14:0] mt, input logic [15:0] fl,
                            input logic [15:0] ce);
    write_reg(CFG_CAL_LOW, lo);
    write_reg(CFG_CAL_HIGH, hi);
    write_reg(CFG_INVERT, {15'd0, inv});
    write_reg(CFG_MAX_TORQUE, {1'b0, mt});
    write_reg(CFG_RAW_FLOOR, fl);
    write_reg(CFG_RAW_CEILING, ce);
    settings_used++;
  endtask

  // hold off until the unit has returned everything it accepted
  task automatic settle();
    int guard;
    guard = 0;
    while (adc_backlog.size() != 0 || smp_if.valid) @(posedge clk_i);
    while (readings_due.size() != 0 && guard < 2000) begin
      @(posedge clk_i);
      guard++;
    end
    if (readings_due.size() != 0) begin
      note_fault($sformatf("%0d readings never arrived", readings_due.size()));
      readings_due.delete();
    end
    repeat (8) @(posedge clk_i);
  endtask

  task automatic random_settings();
    logic [15:0] lo, hi, fl, ce;
    logic        inv;
    logic [14:0] mt;
    case ($urandom_range(0, 5))
      0: begin
        lo = 16'($urandom_range(0, 20000));
        hi = 16'($urandom_range(40000, 65535));
      end
      1: begin
        hi = 16'($urandom_range(0, 20000));
        lo = 16'($urandom_range(40000, 65535));
      end
      2: begin
        lo = 16'($urandom_range(0, 65535));
        hi = lo;
      end
      3: begin
        lo = 16'd0;
        hi = 16'hFFFF;
      end
      4: begin
        lo = 16'($urandom_range(0, 65000));
        hi = lo + 16'($urandom_range(1, 500));
      end
      default: begin
        lo = 16'($urandom);
        hi = 16'($urandom);
      end
    endcase
    inv = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 3))
      0:       mt = 15'd0;
      1:       mt = 15'h7FFF;
      default: mt = 15'($urandom_range(0, 32767));
    endcase
    fl = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2000));
    ce = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(63000, 65535));
    if ($urandom_range(0, 3) == 0)
      write_reg($urandom_range(0, 1) ? IDX_SPARE_A : IDX_SPARE_B, 16'($urandom));
    set_config(lo, hi, inv, mt, fl, ce);
  endtask

  // mostly steady pedal levels with sensor noise, some jumps and raw noise
  task automatic run_phase(input int count);
    int left, kind, level, run, v;
    left = count;
    while (left > 0) begin
      kind = $urandom_range(0, 9);
      case ($urandom_range(0, 3))
        0:       level = 0;
        1:       level = 1023;
        default: level = $urandom_range(0, 1023);
      endcase
      run = (kind <= 6) ? $urandom_range(1, 12) : $urandom_range(1, 4);
      for (int i = 0; i < run && left > 0; i++) begin
        if (kind <= 6) begin
          v = level + int'($urandom_range(0, 16)) - 8;
          if (v < 0) v = 0;
          if (v > 1023) v = 1023;
        end else if (kind == 8) begin
          v = (i % 2) ? 1023 : 0;
        end else begin
          v = $urandom_range(0, 1023);
        end
        adc_backlog.push_back(ADC_W'(v));
        left--;
      end
    end
  endtask

  always @(negedge clk_i) begin
    logic             drive_valid;
    logic [ADC_W-1:0] drive_sample;
    drive_valid  = smp_if.valid;
    drive_sample = smp_if.adc_sample;
    if (!rst_ni) begin
      drive_valid = 1'b0;
    end else if (!smp_if.valid || sample_taken) begin
      drive_valid = 1'b0;
      if (calm) src_gap = 0;
      if (src_gap > 0) begin
        src_gap--;
      end else if (adc_backlog.size() != 0) begin
        if (!calm && $urandom_range(0, 9) == 0) begin
          src_gap = $urandom_range(1, 6) - 1;
        end else begin
          drive_valid  = 1'b1;
          drive_sample = adc_backlog.pop_front();
        end
      end
    end
    smp_if.valid      <= drive_valid;
    smp_if.adc_sample <= drive_sample;
  end

  always @(negedge clk_i) begin
    logic take;
    take = 1'b1;
    if (calm) sink_gap = 0;
    if (sink_gap > 0) begin
      sink_gap--;
      take = 1'b0;
    end else if (!calm && $urandom_range(0, 11) == 0) begin
      sink_gap = $urandom_range(1, 6) - 1;
      take = 1'b0;
    end
    res_if.ready <= take;
  end

  always @(posedge clk_i) begin
    reading_t want;
    sample_taken <= smp_if.valid && smp_if.ready;
    if (rst_ni && smp_if.valid && smp_if.ready) begin
      readings_due.push_back(condition_sample(smp_if.adc_sample));
      samples_sent++;
    end
    if (rst_ni && res_if.valid && res_if.ready) begin
      readings_seen++;
      if (readings_due.size() == 0) begin
        note_fault($sformatf("unexpected transaction: torque %0d cooked %0d flag %0b",
                             res_if.torque_request, res_if.cooked_level,
                             res_if.out_of_range));
      end else begin
        want = readings_due.pop_front();
        if (want.torque !== res_if.torque_request || want.cooked !== res_if.cooked_level ||
            want.oor !== res_if.out_of_range)
          note_fault($sformatf({"reading %0d: expected torque %0d cooked %0d flag %0b,",
                                " got torque %0d cooked %0d flag %0b"},
                               readings_seen, want.torque, want.cooked, want.oor,
                               res_if.torque_request, res_if.cooked_level,
                               res_if.out_of_range));
      end
    end
  end

  initial begin
    cfg_we_i          = 1'b0;
    cfg_idx_i         = '0;
    cfg_data_i        = '0;
    smp_if.valid      = 1'b0;
    smp_if.adc_sample = '0;
    res_if.ready      = 1'b0;
    sample_taken      = 1'b0;
    calm              = 1'b0;
    src_gap           = 0;
    sink_gap          = 0;
    samples_sent      = 0;
    readings_seen     = 0;
    faults            = 0;
    flagged           = 0;
    equal_cal_seen    = 0;
    settings_used     = 1;
    cfg_cal_low       = 16'd0;
    cfg_cal_high      = 16'hFFFF;
    cfg_invert        = 1'b0;
    cfg_max_torque    = 15'd0;
    cfg_floor         = 16'd0;
    cfg_ceiling       = 16'hFFFF;
    foreach (window_ring[i]) window_ring[i] = '0;
    ring_pos          = '0;
    ring_total        = '0;
    rst_ni            = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings, window ramping up from zero
    adc_backlog.push_back(10'd1023);
    adc_backlog.push_back(10'd1023);
    adc_backlog.push_back(10'd0);
    settle();

    // full span, full torque: drive to the top and back down
    set_config(16'd0, 16'd65472, 1'b0, 15'h7FFF, 16'd0, 16'hFFFF);
    repeat (6) adc_backlog.push_back(10'd1023);
    repeat (2) adc_backlog.push_back(10'd0);
    settle();

    // equal calibration points
    set_config(16'd4000, 16'd4000, 1'b0, 15'h7FFF, 16'd0, 16'hFFFF);
    adc_backlog.push_back(10'd512);
    adc_backlog.push_back(10'd7);
    settle();

    // unit span far above the level: torque saturates low
    set_config(16'd65534, 16'd65535, 1'b0, 15'h7FFF, 16'd0, 16'hFFFF);
    adc_backlog.push_back(10'd0);
    settle();

    // reversed points, inverted sensor, floor above ceiling
    set_config(16'hFFFF, 16'd0, 1'b1, 15'h7FFF, 16'd40000, 16'd20000);
    adc_backlog.push_back(10'd341);
    adc_backlog.push_back(10'd682);
    settle();

    write_reg(IDX_SPARE_A, 16'hFFFF);
    write_reg(IDX_SPARE_B, 16'h5555);
    set_config(16'd0, 16'hFFFF, 1'b1, 15'd1, 16'hFFFF, 16'd0);
    adc_backlog.push_back(10'd1023);
    adc_backlog.push_back(10'd512);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      if (p == PHASES - 1) calm = 1'b1;
      random_settings();
      run_phase(PHASE_LEN);
      settle();
    end
    repeat (100) @(posedge clk_i);

    $display("Sent %0d pedal samples across %0d register settings; %0d readings checked.",
             samples_sent, settings_used, readings_seen);
    $display("Of those, %0d carried the range flag and %0d used equal calibration points.",
             flagged, equal_cal_seen);
    if (faults == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d faults", faults);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
